/* design/mrtu_pkg.sv */
// Shared types, constants and the CRC-16 step function of the Modbus RTU master.
`default_nettype none

package mrtu_pkg;

  // Receive buffer depth; the byte count saturates here.
  localparam int RX_DEPTH = 256;
  localparam int RX_CNT_W = $clog2(RX_DEPTH + 1);
  // Stored header bytes: address, function, byte count and four data bytes.
  localparam int HDR_DEPTH = 7;
  localparam int MIN_FRAME = 4;

  // Input and output bus widths.
  localparam int S_TDATA_W = 56;
  localparam int M_TDATA_W = 48;

  // Register reset values. The silence reset is one bit time at 9600 baud
  // counted in cycles of a 35 MHz clock.
  localparam logic [15:0] SILENCE_RESET   = 16'd3645;
  localparam logic [15:0] WATCHED_RESET   = 16'd0;
  localparam logic [7:0]  BYTECOUNT_RESET = 8'd20;

  localparam logic [7:0]  FUNC_READ_INPUT = 8'h04;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_SILENCE   = 2'd0;
  localparam logic [1:0] REG_WATCHED   = 2'd1;
  localparam logic [1:0] REG_BYTECOUNT = 2'd2;

  typedef enum logic [1:0] {
    REQ_SEND = 2'd0,
    REQ_RX   = 2'd1,
    REQ_TICK = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    ST_SHORT    = 2'd0,
    ST_CRC_BAD  = 2'd1,
    ST_CAPTURED = 2'd2,
    ST_IGNORED  = 2'd3
  } frame_status_e;

  typedef enum logic {
    KIND_TX      = 1'b0,
    KIND_VERDICT = 1'b1
  } result_kind_e;

  // Configuration registers as seen by the receive side.
  typedef struct packed {
    logic [15:0] silence_ticks;
    logic [15:0] watched_register;
    logic [7:0]  expected_byte_count;
  } cfg_t;

  // Receive side outcome for the item in the input stage.
  typedef struct packed {
    logic          fire;
    frame_status_e status;
    logic [31:0]   captured_next;
    logic          ack_next;
  } rx_verdict_t;

  // One byte offered by the transmit serializer.
  typedef struct packed {
    logic        valid;
    logic [7:0]  data;
    logic        last;
    logic [31:0] read_value;
    logic        ack;
  } tx_beat_t;

  // One byte folded into the Modbus CRC-16, LSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

/* design/mrtu_rx.sv */
// Receive side: byte store, running CRC, silence timer and frame judging.
`default_nettype none

module mrtu_rx (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire mrtu_pkg::cfg_t      cfg_i,
  input  wire logic                evt_valid_i,
  input  wire mrtu_pkg::req_type_e evt_type_i,
  input  wire logic [2:0]          evt_func_i,
  input  wire logic [15:0]         evt_reg_i,
  input  wire logic [7:0]          evt_byte_i,
  output mrtu_pkg::rx_verdict_t    verdict_o
);
  import mrtu_pkg::*;

  logic [RX_CNT_W-1:0] count_q, count_d;
  logic [15:0]         crc_q, crc_d;
  logic [7:0]          header_q [HDR_DEPTH];
  logic [15:0]         timer_q, timer_d;
  logic                running_q, running_d;
  logic [15:0]         pending_q, pending_d;
  logic                ack_q, ack_d;
  logic [31:0]         captured_q, captured_d;

  logic [15:0]   timer_inc;
  logic          fire;
  logic          capture;
  frame_status_e status;
  logic          hdr_we;
  logic          store_byte;

  // Judge the stored frame as it stands.
  always_comb begin
    capture = 1'b0;
    if (count_q < RX_CNT_W'(MIN_FRAME)) begin
      status = ST_SHORT;
    end else if (crc_q != 16'h0000) begin
      status = ST_CRC_BAD;
    end else if (header_q[1] == FUNC_READ_INPUT &&
                 pending_q == cfg_i.watched_register &&
                 header_q[2] == cfg_i.expected_byte_count) begin
      status  = ST_CAPTURED;
      capture = 1'b1;
    end else begin
      status = ST_IGNORED;
    end
  end

  assign timer_inc  = timer_q + 16'd1;
  assign fire       = (evt_type_i == REQ_TICK) && running_q &&
                      (timer_inc >= cfg_i.silence_ticks);
  assign store_byte = (count_q < RX_CNT_W'(RX_DEPTH));

  // Next state for the item in the input stage.
  always_comb begin
    count_d    = count_q;
    crc_d      = crc_q;
    timer_d    = timer_q;
    running_d  = running_q;
    pending_d  = pending_q;
    ack_d      = ack_q;
    captured_d = captured_q;
    hdr_we     = 1'b0;
    case (evt_type_i)
      REQ_SEND: begin
        if ({5'b0, evt_func_i} == FUNC_READ_INPUT) begin
          ack_d     = 1'b0;
          pending_d = evt_reg_i;
        end
      end
      REQ_RX: begin
        timer_d   = 16'd0;
        running_d = 1'b1;
        if (store_byte) begin
          hdr_we  = (count_q < RX_CNT_W'(HDR_DEPTH));
          crc_d   = crc16_byte(crc_q, evt_byte_i);
          count_d = count_q + RX_CNT_W'(1);
        end
      end
      REQ_TICK: begin
        if (running_q) begin
          if (fire) begin
            if (capture) begin
              captured_d = {header_q[3], header_q[4], header_q[5], header_q[6]};
              ack_d      = 1'b1;
            end
            count_d   = '0;
            crc_d     = CRC_INIT;
            timer_d   = 16'd0;
            running_d = 1'b0;
          end else begin
            timer_d = timer_inc;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign verdict_o.fire          = fire;
  assign verdict_o.status        = status;
  assign verdict_o.captured_next = captured_d;
  assign verdict_o.ack_next      = ack_d;

  // Control and status state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      crc_q      <= CRC_INIT;
      timer_q    <= 16'd0;
      running_q  <= 1'b0;
      pending_q  <= 16'd0;
      ack_q      <= 1'b0;
      captured_q <= 32'd0;
    end else if (evt_valid_i) begin
      count_q    <= count_d;
      crc_q      <= crc_d;
      timer_q    <= timer_d;
      running_q  <= running_d;
      pending_q  <= pending_d;
      ack_q      <= ack_d;
      captured_q <= captured_d;
    end
  end

  // Header bytes hold whatever was last received at their position.
  always_ff @(posedge clk_i) begin
    if (evt_valid_i && hdr_we) begin
      header_q[count_q[2:0]] <= evt_byte_i;
    end
  end

endmodule

`default_nettype wire

/* design/mrtu_tx.sv */
// Transmit side: request frame serializer with a per-byte CRC-16 update.
`default_nettype none

module mrtu_tx (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_i,
  input  wire logic [7:0]  slave_addr_i,
  input  wire logic [2:0]  func_code_i,
  input  wire logic [15:0] reg_addr_i,
  input  wire logic [15:0] count_or_value_i,
  input  wire logic [31:0] read_value_i,
  input  wire logic        ack_i,
  input  wire logic        out_free_i,
  output logic             busy_o,
  output mrtu_pkg::tx_beat_t beat_o
);
  import mrtu_pkg::*;

  logic        busy_q;
  logic [2:0]  idx_q;
  logic [15:0] crc_q;
  logic [7:0]  addr_q;
  logic [2:0]  func_q;
  logic [15:0] reg_q;
  logic [15:0] val_q;
  logic [31:0] value_q;
  logic        ack_q;

  logic [7:0] byte_sel;
  logic       take;
  logic       is_last;

  // Frame byte at the current position; the CRC follows low byte first.
  always_comb begin
    case (idx_q)
      3'd0:    byte_sel = addr_q;
      3'd1:    byte_sel = {5'b0, func_q};
      3'd2:    byte_sel = reg_q[15:8];
      3'd3:    byte_sel = reg_q[7:0];
      3'd4:    byte_sel = val_q[15:8];
      3'd5:    byte_sel = val_q[7:0];
      3'd6:    byte_sel = crc_q[7:0];
      default: byte_sel = crc_q[15:8];
    endcase
  end

  assign is_last = (idx_q == 3'd7);
  assign take    = busy_q && out_free_i;

  assign busy_o            = busy_q;
  assign beat_o.valid      = busy_q;
  assign beat_o.data       = byte_sel;
  assign beat_o.last       = is_last;
  assign beat_o.read_value = value_q;
  assign beat_o.ack        = ack_q;

  // Sequencing: one byte leaves per transaction on the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 3'd0;
      crc_q  <= CRC_INIT;
    end else if (load_i) begin
      busy_q <= 1'b1;
      idx_q  <= 3'd0;
      crc_q  <= CRC_INIT;
    end else if (take) begin
      idx_q <= idx_q + 3'd1;
      if (is_last) begin
        busy_q <= 1'b0;
      end
      if (idx_q < 3'd6) begin
        crc_q <= crc16_byte(crc_q, byte_sel);
      end
    end
  end

  // Frame content and the status snapshot taken with the request.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      addr_q  <= slave_addr_i;
      func_q  <= func_code_i;
      reg_q   <= reg_addr_i;
      val_q   <= count_or_value_i;
      value_q <= read_value_i;
      ack_q   <= ack_i;
    end
  end

endmodule

`default_nettype wire

/* design/modbus_rtu_master_frame_engine_top.sv */
// Modbus RTU master frame engine: input stage, configuration and output register.
// Path: a received byte updates the receive state as it leaves the input stage;
// a verdict passes the input stage and the output register, a request byte the
// serializer too. Throughput: one received byte or tick per cycle unless the output
// stalls or a frame streams; a send request holds the input while its bytes stream out.
// Reset: asynchronous, active low; resets counters, CRC, timer, flags and config registers.
`default_nettype none

module modbus_rtu_master_frame_engine_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Request stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: slave_addr[7:0], func_code[10:8], reg_addr[26:11],
  // count_or_value[42:27], rx_byte[50:43], zero[55:51]
  input  wire logic [55:0] s_axis_tdata,
  // tuser: req_type[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  // Result stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: tx_byte[7:0], frame_status[9:8], read_value[41:10],
  // ack_flag[42], zero[47:43]
  output logic [47:0]      m_axis_tdata,
  // tuser: result_kind[0]
  output logic [0:0]       m_axis_tuser,
  output logic             m_axis_tlast,
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import mrtu_pkg::*;

  // Configuration registers.
  cfg_t        cfg_q;
  logic        cfg_we;
  logic [1:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.silence_ticks       <= SILENCE_RESET;
      cfg_q.watched_register    <= WATCHED_RESET;
      cfg_q.expected_byte_count <= BYTECOUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SILENCE:   cfg_q.silence_ticks       <= pwdata[15:0];
        REG_WATCHED:   cfg_q.watched_register    <= pwdata[15:0];
        REG_BYTECOUNT: cfg_q.expected_byte_count <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (cfg_idx)
      REG_SILENCE:   prdata = {16'd0, cfg_q.silence_ticks};
      REG_WATCHED:   prdata = {16'd0, cfg_q.watched_register};
      REG_BYTECOUNT: prdata = {24'd0, cfg_q.expected_byte_count};
      default:       prdata = 32'd0;
    endcase
  end

  // Input stage.
  logic        in_valid_q;
  req_type_e   in_type_q;
  logic [7:0]  in_addr_q;
  logic [2:0]  in_func_q;
  logic [15:0] in_reg_q;
  logic [15:0] in_val_q;
  logic [7:0]  in_byte_q;

  logic        out_free;
  logic        tx_busy;
  logic        advance;
  logic        in_take;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign advance       = in_valid_q && !tx_busy && out_free;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_type_q <= req_type_e'(s_axis_tuser);
      in_addr_q <= s_axis_tdata[7:0];
      in_func_q <= s_axis_tdata[10:8];
      in_reg_q  <= s_axis_tdata[26:11];
      in_val_q  <= s_axis_tdata[42:27];
      in_byte_q <= s_axis_tdata[50:43];
    end
  end

  // Receive side.
  rx_verdict_t verdict;

  mrtu_rx u_rx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .evt_valid_i (advance),
    .evt_type_i  (in_type_q),
    .evt_func_i  (in_func_q),
    .evt_reg_i   (in_reg_q),
    .evt_byte_i  (in_byte_q),
    .verdict_o   (verdict)
  );

  // Transmit side.
  tx_beat_t tx_beat;
  logic     tx_load;
  logic     tx_take;
  logic     verdict_load;

  assign tx_load      = advance && (in_type_q == REQ_SEND);
  assign tx_take      = tx_beat.valid && out_free;
  assign verdict_load = advance && verdict.fire;

  mrtu_tx u_tx (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .load_i           (tx_load),
    .slave_addr_i     (in_addr_q),
    .func_code_i      (in_func_q),
    .reg_addr_i       (in_reg_q),
    .count_or_value_i (in_val_q),
    .read_value_i     (verdict.captured_next),
    .ack_i            (verdict.ack_next),
    .out_free_i       (out_free),
    .busy_o           (tx_busy),
    .beat_o           (tx_beat)
  );

  // Output register.
  logic          out_valid_q;
  result_kind_e  out_kind_q;
  logic [7:0]    out_byte_q;
  logic          out_last_q;
  frame_status_e out_status_q;
  logic [31:0]   out_value_q;
  logic          out_ack_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (tx_take || verdict_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tx_take) begin
      out_kind_q   <= KIND_TX;
      out_byte_q   <= tx_beat.data;
      out_last_q   <= tx_beat.last;
      out_status_q <= ST_SHORT;
      out_value_q  <= tx_beat.read_value;
      out_ack_q    <= tx_beat.ack;
    end else if (verdict_load) begin
      out_kind_q   <= KIND_VERDICT;
      out_byte_q   <= 8'd0;
      out_last_q   <= 1'b0;
      out_status_q <= verdict.status;
      out_value_q  <= verdict.captured_next;
      out_ack_q    <= verdict.ack_next;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {5'd0, out_ack_q, out_value_q, out_status_q, out_byte_q};

`ifndef NO_ASSERTIONS
  // The serializer and the verdict path never claim the output register together.
  a_one_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(tx_take && verdict_load))
    else $error("transmit byte and verdict loaded in the same cycle");

  // A send leaving the input stage starts the serializer.
  a_send_starts_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_load |=> tx_busy)
    else $error("send request did not start the serializer");

  // Only transmit bytes carry the frame end mark.
  a_last_is_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser[0] == KIND_TX))
    else $error("frame end mark on a verdict");

  // No item leaves the input stage while a frame is still streaming.
  a_hold_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tx_busy && in_valid_q) |=> in_valid_q)
    else $error("input item consumed while the serializer was busy");
`endif

endmodule

`default_nettype wire
